[hdl/bmp_pkg.sv]
// bmp_pkg: shared types and constants of the bmp stream to rgba decoder
// item structs for both channels, header offsets, phase and status codes
// no dependencies
`default_nettype none

package bmp_pkg;

  localparam int HEADER_BYTES = 54;
  localparam int POS_W        = 35;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  // header byte offsets
  localparam logic [POS_W-1:0] OFS_MARK0 = 35'd0;
  localparam logic [POS_W-1:0] OFS_MARK1 = 35'd1;
  localparam logic [POS_W-1:0] OFS_OFF_L = 35'd10;
  localparam logic [POS_W-1:0] OFS_OFF_H = 35'd11;
  localparam logic [POS_W-1:0] OFS_WID_L = 35'd18;
  localparam logic [POS_W-1:0] OFS_WID_H = 35'd19;
  localparam logic [POS_W-1:0] OFS_HGT_L = 35'd22;
  localparam logic [POS_W-1:0] OFS_HGT_H = 35'd23;
  localparam logic [POS_W-1:0] OFS_DEPTH = 35'd28;
  localparam logic [POS_W-1:0] OFS_LAST  = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};

  localparam logic [7:0] CHAR_B    = 8'h42;
  localparam logic [7:0] CHAR_M    = 8'h4d;
  localparam logic [7:0] DEPTH_24  = 8'd24;
  localparam logic [7:0] DEPTH_32  = 8'd32;
  localparam logic [7:0] ALPHA_MAX = 8'd255;

  // phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_MARKER    = 3'd2;
  localparam logic [2:0] ST_DEPTH     = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;
  localparam logic [2:0] ST_OFFSET    = 3'd5;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [2:0]  status_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] column;
    logic [15:0] top_row;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last_item;
  } out_item_t;

  // results of one decoded byte: a pixel, then the status, either optional
  typedef struct packed {
    logic      pix_valid;
    out_item_t pix;
    logic      stat_valid;
    out_item_t stat;
  } result_pair_t;

endpackage

`default_nettype wire

[hdl/bmp_stream_to_rgba_top.sv]
// bmp_stream_to_rgba_top: byte-serial decoder of 24-bit and 32-bit bmp files
// instantiates bmp_decode and bmp_out_queue; uses bmp_pkg
//
// usage:
//   byte channel (byte_valid/byte_stall/byte_data) takes the file one byte
//   per item, end_of_file set on the last byte. result channel
//   (res_valid/res_stall/res_data) gives rgba pixel items with column and
//   top-down row, and one status item (last_item set) after the final byte.
//   pixels stream before the status is known; drop them on an error status.
//   a byte waits in the input register until the queue has room; its results are then written into the queue.
//   throughput: one byte per cycle; a byte may cause a pixel and the status,
//   which a four-entry result queue absorbs, so the input stalls only while
//   the queue has fewer than two free slots, which takes a stalling receiver.
//   the byte input register holds one item while the queue is short of room.
//   reset (rst, synchronous) empties the queue and input register and returns
//   the decoder to the header phase; a stalled result item stays unchanged.
`default_nettype none

module bmp_stream_to_rgba_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_valid,
  output logic                     byte_stall,
  input  wire bmp_pkg::in_item_t   byte_data,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output bmp_pkg::out_item_t       res_data
);

  bmp_pkg::in_item_t          in_item;
  logic                       in_full;
  logic                       go;
  logic                       room;
  logic [bmp_pkg::QCNT_W-1:0] level;
  bmp_pkg::result_pair_t      results;

  assign go         = in_full && room;
  assign byte_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_item <= byte_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  bmp_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .item    (in_item),
    .results (results)
  );

  bmp_out_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (go),
    .results (results),
    .room    (room),
    .level   (level),
    .valid   (res_valid),
    .stall   (res_stall),
    .data    (res_data)
  );

  // queue never holds more than its depth
  assert property (@(posedge clk) disable iff (rst)
    level <= bmp_pkg::QCNT_W'(bmp_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // nothing is offered right after reset
  assert property (@(posedge clk) rst |=> !res_valid && !byte_stall)
    else $error("output active after reset");

  // status items end the file, pixel items never do
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.item_kind == res_data.last_item))
    else $error("last_item does not match item kind");

  // a byte that ends the file always yields a status item
  assert property (@(posedge clk) disable iff (rst)
    go && in_item.end_of_file |-> results.stat_valid)
    else $error("end of file without status");

endmodule

`default_nettype wire

[hdl/bmp_decode.sv]
// bmp_decode: header parser, pixel assembler and status generator
// updates its state once per byte when go is high; uses bmp_pkg
`default_nettype none

module bmp_decode (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  go,
  input  wire bmp_pkg::in_item_t     item,
  output bmp_pkg::result_pair_t      results
);

  logic [bmp_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [15:0] pixel_start, pixel_start_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic        four_channels, four_channels_next;
  logic [15:0] col_count, col_count_next;
  logic [16:0] file_row_count, file_row_count_next;
  logic [1:0]  channel_index, channel_index_next;
  logic [1:0]  pad_remaining, pad_remaining_next;
  logic [7:0]  held_b, held_b_next;
  logic [7:0]  held_g, held_g_next;
  logic [7:0]  held_r, held_r_next;
  logic [2:0]  error_state, error_state_next;
  logic [1:0]  phase, phase_next;

  logic [7:0]  b;
  logic        empty;
  logic        empty_hdr;
  logic        pixel_byte;
  logic        emit;
  logic [7:0]  emit_alpha;
  logic [1:0]  pad;
  logic [bmp_pkg::POS_W:0] pos_plus1;
  logic [2:0]  code;

  always_comb begin
    b = item.file_byte;
    byte_position_next  = byte_position;
    pixel_start_next    = pixel_start;
    width_reg_next      = width_reg;
    height_reg_next     = height_reg;
    four_channels_next  = four_channels;
    col_count_next      = col_count;
    file_row_count_next = file_row_count;
    channel_index_next  = channel_index;
    pad_remaining_next  = pad_remaining;
    held_b_next         = held_b;
    held_g_next         = held_g;
    held_r_next         = held_r;
    error_state_next    = error_state;
    phase_next          = phase;
    results             = '0;
    empty      = (width_reg == 16'd0) || (height_reg == 16'd0);
    empty_hdr  = 1'b0;
    pixel_byte = 1'b0;
    emit       = 1'b0;
    emit_alpha = bmp_pkg::ALPHA_MAX;
    pad        = 2'd0;
    code       = bmp_pkg::ST_OK;
    pos_plus1  = {1'b0, byte_position} + 36'd1;

    if (phase == bmp_pkg::PH_HEADER) begin
      case (byte_position)
        bmp_pkg::OFS_MARK0: begin
          if (b != bmp_pkg::CHAR_B && error_state == bmp_pkg::ST_OK) begin
            error_state_next = bmp_pkg::ST_MARKER;
          end
        end
        bmp_pkg::OFS_MARK1: begin
          if (b != bmp_pkg::CHAR_M && error_state == bmp_pkg::ST_OK) begin
            error_state_next = bmp_pkg::ST_MARKER;
          end
        end
        bmp_pkg::OFS_OFF_L: pixel_start_next[7:0]  = b;
        bmp_pkg::OFS_OFF_H: pixel_start_next[15:8] = b;
        bmp_pkg::OFS_WID_L: width_reg_next[7:0]    = b;
        bmp_pkg::OFS_WID_H: width_reg_next[15:8]   = b;
        bmp_pkg::OFS_HGT_L: height_reg_next[7:0]   = b;
        bmp_pkg::OFS_HGT_H: height_reg_next[15:8]  = b;
        bmp_pkg::OFS_DEPTH: begin
          if (b != bmp_pkg::DEPTH_24 && b != bmp_pkg::DEPTH_32) begin
            if (error_state == bmp_pkg::ST_OK) begin
              error_state_next = bmp_pkg::ST_DEPTH;
            end
          end else begin
            four_channels_next = (b == bmp_pkg::DEPTH_32);
          end
        end
        default: ;
      endcase
      if (byte_position == bmp_pkg::OFS_LAST) begin
        empty_hdr = (width_reg_next == 16'd0) || (height_reg_next == 16'd0);
        if (error_state_next == bmp_pkg::ST_OK &&
            pixel_start_next < 16'(bmp_pkg::HEADER_BYTES)) begin
          error_state_next = bmp_pkg::ST_OFFSET;
        end
        if (error_state_next != bmp_pkg::ST_OK) begin
          phase_next = bmp_pkg::PH_DONE;
        end else if (empty_hdr && pixel_start_next <= 16'(bmp_pkg::HEADER_BYTES)) begin
          phase_next = bmp_pkg::PH_DONE;
        end else begin
          phase_next = bmp_pkg::PH_SKIP;
        end
      end
    end else if (error_state == bmp_pkg::ST_OK && phase == bmp_pkg::PH_SKIP) begin
      if (empty) begin
        if (pos_plus1 >= {20'd0, pixel_start}) begin
          phase_next = bmp_pkg::PH_DONE;
        end
      end else if (byte_position >= {19'd0, pixel_start}) begin
        phase_next = bmp_pkg::PH_PIXELS;
        pixel_byte = 1'b1;
      end
    end else if (error_state == bmp_pkg::ST_OK && phase == bmp_pkg::PH_PIXELS) begin
      pixel_byte = 1'b1;
    end

    if (pixel_byte) begin
      if (pad_remaining != 2'd0) begin
        pad_remaining_next = pad_remaining - 2'd1;
        if (pad_remaining_next == 2'd0 && file_row_count >= {1'b0, height_reg}) begin
          phase_next = bmp_pkg::PH_DONE;
        end
      end else if (channel_index != 2'd3) begin
        case (channel_index)
          2'd0:    held_b_next = b;
          2'd1:    held_g_next = b;
          default: held_r_next = b;
        endcase
        channel_index_next = channel_index + 2'd1;
        if (channel_index == 2'd2 && !four_channels) begin
          emit = 1'b1;
        end
      end else begin
        emit       = 1'b1;
        emit_alpha = b;
      end
    end

    if (emit) begin
      results.pix_valid         = 1'b1;
      results.pix.item_kind     = bmp_pkg::KIND_PIXEL;
      results.pix.red           = held_r_next;
      results.pix.green         = held_g_next;
      results.pix.blue          = held_b_next;
      results.pix.alpha         = emit_alpha;
      results.pix.column        = col_count;
      results.pix.top_row       = height_reg - 16'd1 - file_row_count[15:0];
      channel_index_next = 2'd0;
      col_count_next     = col_count + 16'd1;
      if (col_count_next == width_reg) begin
        col_count_next      = 16'd0;
        file_row_count_next = file_row_count + 17'd1;
        // 24-bit rows of width w need (w mod 4) pad bytes
        pad = four_channels ? 2'd0 : width_reg[1:0];
        if (pad == 2'd0) begin
          if (file_row_count_next >= {1'b0, height_reg}) begin
            phase_next = bmp_pkg::PH_DONE;
          end
        end else begin
          pad_remaining_next = pad;
        end
      end
    end

    if (byte_position != bmp_pkg::POS_LIMIT) begin
      byte_position_next = byte_position + 35'd1;
    end

    if (item.end_of_file) begin
      if (phase_next == bmp_pkg::PH_HEADER) begin
        code = bmp_pkg::ST_SHORT;
      end else if (error_state_next != bmp_pkg::ST_OK) begin
        code = error_state_next;
      end else if (phase_next != bmp_pkg::PH_DONE) begin
        code = bmp_pkg::ST_TRUNCATED;
      end else begin
        code = bmp_pkg::ST_OK;
      end
      results.stat_valid         = 1'b1;
      results.stat.item_kind     = bmp_pkg::KIND_STATUS;
      results.stat.status_code   = code;
      results.stat.image_width   = width_reg_next;
      results.stat.image_height  = height_reg_next;
      results.stat.last_item     = 1'b1;
      // back to the reset state for the next file
      byte_position_next  = '0;
      pixel_start_next    = '0;
      width_reg_next      = '0;
      height_reg_next     = '0;
      four_channels_next  = 1'b0;
      col_count_next      = '0;
      file_row_count_next = '0;
      channel_index_next  = '0;
      pad_remaining_next  = '0;
      held_b_next         = '0;
      held_g_next         = '0;
      held_r_next         = '0;
      error_state_next    = bmp_pkg::ST_OK;
      phase_next          = bmp_pkg::PH_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      pixel_start    <= '0;
      width_reg      <= '0;
      height_reg     <= '0;
      four_channels  <= 1'b0;
      col_count      <= '0;
      file_row_count <= '0;
      channel_index  <= '0;
      pad_remaining  <= '0;
      held_b         <= '0;
      held_g         <= '0;
      held_r         <= '0;
      error_state    <= bmp_pkg::ST_OK;
      phase          <= bmp_pkg::PH_HEADER;
    end else if (go) begin
      byte_position  <= byte_position_next;
      pixel_start    <= pixel_start_next;
      width_reg      <= width_reg_next;
      height_reg     <= height_reg_next;
      four_channels  <= four_channels_next;
      col_count      <= col_count_next;
      file_row_count <= file_row_count_next;
      channel_index  <= channel_index_next;
      pad_remaining  <= pad_remaining_next;
      held_b         <= held_b_next;
      held_g         <= held_g_next;
      held_r         <= held_r_next;
      error_state    <= error_state_next;
      phase          <= phase_next;
    end
  end

endmodule

`default_nettype wire

[hdl/bmp_out_queue.sv]
// bmp_out_queue: four-entry result queue, takes up to two items per cycle
// and hands out one unless stalled; uses bmp_pkg
`default_nettype none

module bmp_out_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire bmp_pkg::result_pair_t      results,
  output logic                            room,
  output logic [bmp_pkg::QCNT_W-1:0]      level,
  output logic                            valid,
  input  wire logic                       stall,
  output bmp_pkg::out_item_t              data
);

  bmp_pkg::out_item_t entries [bmp_pkg::QUEUE_DEPTH];
  logic [bmp_pkg::QPTR_W-1:0] wr_ptr;
  logic [bmp_pkg::QPTR_W-1:0] rd_ptr;
  logic [bmp_pkg::QCNT_W-1:0] level_next;
  logic                       pop;
  logic                       put_pix;
  logic                       put_stat;
  logic [bmp_pkg::QPTR_W-1:0] stat_ptr;
  logic [bmp_pkg::QCNT_W-1:0] n_put;

  // room means at least two free entries, enough for the next byte
  assign room  = level <= bmp_pkg::QCNT_W'(bmp_pkg::QUEUE_DEPTH - 2);
  assign valid = level != '0;
  assign data  = entries[rd_ptr];
  assign pop   = valid && !stall;

  assign put_pix  = push && results.pix_valid;
  assign put_stat = push && results.stat_valid;
  assign stat_ptr = put_pix ? wr_ptr + 2'd1 : wr_ptr;
  assign n_put    = {2'b00, put_pix} + {2'b00, put_stat};
  assign level_next = level + n_put - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (put_pix) begin
      entries[wr_ptr] <= results.pix;
    end
    if (put_stat) begin
      entries[stat_ptr] <= results.stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_put[bmp_pkg::QPTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      level <= level_next;
    end
  end

endmodule

`default_nettype wire
